// ===== hw/rtl/qrs_pkg.sv =====
// shared widths, root kind codes and pipeline sideband types for the quadratic root solver
package qrs_pkg;

	localparam int COEF_W    = 16;
	localparam int FRAC_BITS = 16;
	localparam int OUT_W     = 35;

	// |b*b - 4ac| needs one bit more than a full product
	localparam int MAG_W   = 2 * COEF_W + 1;
	localparam int RAD_W   = MAG_W + 2 * FRAC_BITS;
	localparam int RAD_PAD = RAD_W + (RAD_W % 2);
	localparam int ROOT_W  = RAD_PAD / 2;
	localparam int REM_W   = ROOT_W + 2;
	localparam int NB_W    = COEF_W + FRAC_BITS + 1;
	localparam int NUM_W   = ROOT_W + 2;
	localparam int DEN_W   = COEF_W + 1;
	localparam int TDATA_W = ((4 * OUT_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		KIND_REAL,
		KIND_DOUBLE,
		KIND_COMPLEX,
		KIND_INVALID
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic signed [NB_W-1:0] nb;
		logic [DEN_W-1:0]       den_mag;
		logic                   den_neg;
	} sq_side_t;

	typedef struct packed {
		kind_t kind;
		logic  x_neg;
		logic  y_neg;
	} dv_side_t;

endpackage

// ===== hw/rtl/qrs_sqrt.sv =====
// pipelined floor square root, one root bit per stage
module qrs_sqrt
	import qrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [MAG_W-1:0]  in_mag,
	input  sq_side_t          in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output sq_side_t          out_side
);

	logic                vld_s  [ROOT_W];
	logic [RAD_PAD-1:0]  rad_s  [ROOT_W];
	logic [ROOT_W-1:0]   root_s [ROOT_W];
	logic [REM_W-1:0]    rem_s  [ROOT_W];
	sq_side_t            side_s [ROOT_W];

	genvar i;
	generate
		for (i = 0; i < ROOT_W; i++) begin : g_stage
			logic               p_vld;
			logic [RAD_PAD-1:0] p_rad;
			logic [ROOT_W-1:0]  p_root;
			logic [REM_W-1:0]   p_rem;
			sq_side_t           p_side;
			logic [REM_W+1:0]   cur;
			logic [REM_W+1:0]   trial;
			logic               ge;

			if (i == 0) begin : g_first
				assign p_vld  = in_valid;
				assign p_rad  = RAD_PAD'(in_mag) << (2 * FRAC_BITS);
				assign p_root = '0;
				assign p_rem  = '0;
				assign p_side = in_side;
			end else begin : g_next
				assign p_vld  = vld_s[i-1];
				assign p_rad  = rad_s[i-1];
				assign p_root = root_s[i-1];
				assign p_rem  = rem_s[i-1];
				assign p_side = side_s[i-1];
			end

			// bring down the next two radicand bits and try root bit one
			assign cur   = {p_rem, p_rad[RAD_PAD-1 -: 2]};
			assign trial = {2'b00, p_root, 2'b01};
			assign ge    = (cur >= trial);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i] <= 1'b0;
				end else if (en) begin
					vld_s[i] <= p_vld;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[i]  <= p_rad << 2;
					root_s[i] <= {p_root[ROOT_W-2:0], ge};
					rem_s[i]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
					side_s[i] <= p_side;
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[ROOT_W-1];
	assign out_root  = root_s[ROOT_W-1];
	assign out_side  = side_s[ROOT_W-1];

endmodule

// ===== hw/rtl/qrs_div.sv =====
// two pipelined unsigned dividers sharing a divisor, one quotient bit per stage
module qrs_div
	import qrs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] in_x,
	input  logic [NUM_W-1:0] in_y,
	input  logic [DEN_W-1:0] in_den,
	input  dv_side_t         in_side,
	output logic             out_valid,
	output logic [NUM_W-1:0] out_qx,
	output logic [NUM_W-1:0] out_qy,
	output dv_side_t         out_side
);

	logic             vld_s  [NUM_W];
	logic [NUM_W-1:0] x_s    [NUM_W];
	logic [NUM_W-1:0] y_s    [NUM_W];
	logic [DEN_W-1:0] rx_s   [NUM_W];
	logic [DEN_W-1:0] ry_s   [NUM_W];
	logic [DEN_W-1:0] den_s  [NUM_W];
	dv_side_t         side_s [NUM_W];

	genvar i;
	generate
		for (i = 0; i < NUM_W; i++) begin : g_stage
			logic             p_vld;
			logic [NUM_W-1:0] p_x;
			logic [NUM_W-1:0] p_y;
			logic [DEN_W-1:0] p_rx;
			logic [DEN_W-1:0] p_ry;
			logic [DEN_W-1:0] p_den;
			dv_side_t         p_side;
			logic [DEN_W:0]   cx;
			logic [DEN_W:0]   cy;
			logic             gx;
			logic             gy;

			if (i == 0) begin : g_first
				assign p_vld  = in_valid;
				assign p_x    = in_x;
				assign p_y    = in_y;
				assign p_rx   = '0;
				assign p_ry   = '0;
				assign p_den  = in_den;
				assign p_side = in_side;
			end else begin : g_next
				assign p_vld  = vld_s[i-1];
				assign p_x    = x_s[i-1];
				assign p_y    = y_s[i-1];
				assign p_rx   = rx_s[i-1];
				assign p_ry   = ry_s[i-1];
				assign p_den  = den_s[i-1];
				assign p_side = side_s[i-1];
			end

			// dividend shifts out the top while quotient bits fill the bottom
			assign cx = {p_rx, p_x[NUM_W-1]};
			assign cy = {p_ry, p_y[NUM_W-1]};
			assign gx = (cx >= {1'b0, p_den});
			assign gy = (cy >= {1'b0, p_den});

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i] <= 1'b0;
				end else if (en) begin
					vld_s[i] <= p_vld;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					x_s[i]    <= {p_x[NUM_W-2:0], gx};
					y_s[i]    <= {p_y[NUM_W-2:0], gy};
					rx_s[i]   <= gx ? DEN_W'(cx - {1'b0, p_den}) : DEN_W'(cx);
					ry_s[i]   <= gy ? DEN_W'(cy - {1'b0, p_den}) : DEN_W'(cy);
					den_s[i]  <= p_den;
					side_s[i] <= p_side;
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[NUM_W-1];
	assign out_qx    = x_s[NUM_W-1];
	assign out_qy    = y_s[NUM_W-1];
	assign out_side  = side_s[NUM_W-1];

endmodule

// ===== hw/rtl/quadratic_root_solver.sv =====
// top level of the quadratic root solver: discriminant, square root and division pipeline
//
// Takes coefficients a, b, c as one request on the s_axis channel and returns
// both roots of a*x^2 + b*x + c in signed Q.16 on the m_axis channel, with a
// root kind in tuser (distinct real, double real, complex pair, invalid a=0).
// The pipeline is 72 register stages deep, the first loaded at the accepting
// edge: a products stage, a discriminant stage, 33 square root stages (one
// root bit each), a stage forming the numerators, 35 divider stages (one
// quotient bit each, two dividers side by side) and the output register.
// Throughput is one request per cycle while m_axis_tready does not hold the
// pipeline; every stage is a plain register.
// When m_axis_tready is low and a result waits, the whole pipeline holds and
// s_axis_tready drops, so nothing is lost or repeated; s_axis_tready is high
// whenever the output register is empty or being drained.
// Reset clears all valid bits; the pipeline is empty and ready right after.
module quadratic_root_solver
	import qrs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [47:0]        s_axis_tdata,  // coef_a, coef_b, coef_c
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,  // first_real, first_imag, second_real, second_imag, zero pad
	output logic [1:0]         m_axis_tuser   // root_kind
);

	logic en;

	// stage 1: magnitudes and products
	logic signed [COEF_W-1:0] ca, cb, cc;
	logic [COEF_W-1:0]        am, bm, cm;
	logic signed [NB_W-1:0]   b_ext;

	logic                     vld_s1;
	logic                     az_s1, cz_s1, sdiff_s1;
	logic [2*COEF_W-1:0]      b2_s1, p_s1;
	logic signed [NB_W-1:0]   nb_s1;
	logic [DEN_W-1:0]         den_s1;
	logic                     dneg_s1;

	assign ca = s_axis_tdata[COEF_W-1:0];
	assign cb = s_axis_tdata[2*COEF_W-1:COEF_W];
	assign cc = s_axis_tdata[3*COEF_W-1:2*COEF_W];
	assign am = ca[COEF_W-1] ? COEF_W'(-ca) : COEF_W'(ca);
	assign bm = cb[COEF_W-1] ? COEF_W'(-cb) : COEF_W'(cb);
	assign cm = cc[COEF_W-1] ? COEF_W'(-cc) : COEF_W'(cc);
	assign b_ext = NB_W'(cb);

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			az_s1    <= (ca == '0);
			cz_s1    <= (cc == '0);
			sdiff_s1 <= ca[COEF_W-1] ^ cc[COEF_W-1];
			b2_s1    <= bm * bm;
			p_s1     <= am * cm;
			nb_s1    <= -(b_ext <<< FRAC_BITS);
			den_s1   <= {am, 1'b0};
			dneg_s1  <= ca[COEF_W-1];
		end
	end

	// stage 2: discriminant magnitude, sign and kind
	logic [2*COEF_W+1:0] four_ac, b2_w;
	logic [MAG_W-1:0]    mag_c;
	logic                neg_c;
	kind_t               kind_c;

	logic                vld_s2;
	logic [MAG_W-1:0]    mag_s2;
	sq_side_t            side_s2;

	always_comb begin
		four_ac = {p_s1, 2'b00};
		b2_w    = {2'b00, b2_s1};
		neg_c   = 1'b0;
		if (sdiff_s1 || cz_s1) begin
			mag_c = MAG_W'(b2_w + four_ac);
		end else if (four_ac <= b2_w) begin
			mag_c = MAG_W'(b2_w - four_ac);
		end else begin
			mag_c = MAG_W'(four_ac - b2_w);
			neg_c = 1'b1;
		end
		if (az_s1) begin
			kind_c = KIND_INVALID;
		end else if (mag_c == '0) begin
			kind_c = KIND_DOUBLE;
		end else if (neg_c) begin
			kind_c = KIND_COMPLEX;
		end else begin
			kind_c = KIND_REAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2          <= mag_c;
			side_s2.kind    <= kind_c;
			side_s2.nb      <= nb_s1;
			side_s2.den_mag <= den_s1;
			side_s2.den_neg <= dneg_s1;
		end
	end

	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	sq_side_t          sq_side;

	qrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.in_mag    (mag_s2),
		.in_side   (side_s2),
		.out_valid (sq_vld),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// numerators: x over den gives the real parts, y the second real or the imaginary
	logic signed [NUM_W:0] nbx, rtx, x_c, y_c;

	logic                  vld_s3;
	logic [NUM_W-1:0]      xm_s3, ym_s3;
	logic [DEN_W-1:0]      den_s3;
	dv_side_t              dside_s3;

	assign nbx = (NUM_W+1)'(sq_side.nb);
	assign rtx = (NUM_W+1)'(sq_root);

	always_comb begin
		if (sq_side.kind == KIND_COMPLEX) begin
			x_c = nbx;
			y_c = rtx;
		end else begin
			x_c = nbx + rtx;
			y_c = nbx - rtx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xm_s3          <= x_c[NUM_W] ? NUM_W'(-x_c) : NUM_W'(x_c);
			ym_s3          <= y_c[NUM_W] ? NUM_W'(-y_c) : NUM_W'(y_c);
			den_s3         <= sq_side.den_mag;
			dside_s3.kind  <= sq_side.kind;
			dside_s3.x_neg <= x_c[NUM_W] ^ sq_side.den_neg;
			dside_s3.y_neg <= y_c[NUM_W] ^ sq_side.den_neg;
		end
	end

	logic             dv_vld;
	logic [NUM_W-1:0] qx, qy;
	dv_side_t         dv_side;

	qrs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_x      (xm_s3),
		.in_y      (ym_s3),
		.in_den    (den_s3),
		.in_side   (dside_s3),
		.out_valid (dv_vld),
		.out_qx    (qx),
		.out_qy    (qy),
		.out_side  (dv_side)
	);

	// output register
	logic signed [OUT_W-1:0] fx, fy;
	logic signed [OUT_W-1:0] r1_c, i1_c, r2_c, i2_c;

	logic signed [OUT_W-1:0] r1_q, i1_q, r2_q, i2_q;
	kind_t                   kind_q;
	logic                    out_vld_q;

	assign fx = dv_side.x_neg ? -OUT_W'(qx) : OUT_W'(qx);
	assign fy = dv_side.y_neg ? -OUT_W'(qy) : OUT_W'(qy);

	always_comb begin
		r1_c = '0;
		i1_c = '0;
		r2_c = '0;
		i2_c = '0;
		case (dv_side.kind)
			KIND_REAL: begin
				r1_c = fx;
				r2_c = fy;
			end
			KIND_DOUBLE: begin
				r1_c = fx;
				r2_c = fx;
			end
			KIND_COMPLEX: begin
				r1_c = fx;
				r2_c = fx;
				i1_c = fy;
				i2_c = -fy;
			end
			default: begin
				r1_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r1_q   <= r1_c;
			i1_q   <= i1_c;
			r2_q   <= r2_c;
			i2_q   <= i2_c;
			kind_q <= dv_side.kind;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = TDATA_W'({i2_q, r2_q, i1_q, r1_q});
	assign m_axis_tuser  = kind_q;

endmodule
